### design/brainfuck_execution_core_unit_defines.svh
// assertion helpers for the execution core
`ifndef BRAINFUCK_EXECUTION_CORE_UNIT_DEFINES_SVH
`define BRAINFUCK_EXECUTION_CORE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define BFEC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BFEC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bfec_pkg.sv
`default_nettype none

package bfec_pkg;

   // item kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EXEC = 1'b1;

   // command characters
   localparam logic [7:0] SYM_RIGHT = 8'h3E;
   localparam logic [7:0] SYM_LEFT  = 8'h3C;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_DOT   = 8'h2E;
   localparam logic [7:0] SYM_COMMA = 8'h2C;
   localparam logic [7:0] SYM_OPEN  = 8'h5B;
   localparam logic [7:0] SYM_CLOSE = 8'h5D;

   // status codes
   localparam logic [2:0] STATUS_OK              = 3'd0;
   localparam logic [2:0] STATUS_UNMATCHED_CLOSE = 3'd1;
   localparam logic [2:0] STATUS_UNMATCHED_OPEN  = 3'd2;
   localparam logic [2:0] STATUS_UNDERFLOW       = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW        = 3'd4;
   localparam logic [2:0] STATUS_NEST_OVERFLOW   = 3'd5;

   localparam int POS_W  = 12;
   localparam int PC_W   = 13;
   localparam int BYTE_W = 8;

   typedef struct packed {
      logic              req_type;
      logic [BYTE_W-1:0] symbol;
      logic [POS_W-1:0]  position;
      logic              load_last;
      logic [BYTE_W-1:0] in_byte;
   } req_item_type;

   typedef struct packed {
      logic [PC_W-1:0]   next_pc;
      logic              out_valid;
      logic [BYTE_W-1:0] out_byte;
      logic [2:0]        status;
   } rsp_item_type;

   // conditions the decoder needs from the stored state
   typedef struct packed {
      logic pos_ok;
      logic ptr_at_zero;
      logic ptr_at_last;
      logic count_zero;
      logic count_one;
      logic count_full;
   } exec_flags_type;

   // state updates requested by the decoder
   typedef struct packed {
      logic              ptr_inc;
      logic              ptr_dec;
      logic              tape_we;
      logic [BYTE_W-1:0] tape_wdata;
      logic              push;
      logic              pop;
      logic              clear_count;
   } exec_ctl_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_LINK
   } core_state_type;

endpackage

`default_nettype wire

### design/bfec_chan_if.sv
`default_nettype none

interface bfec_req_if;
   logic                  valid;
   logic                  ready;
   bfec_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bfec_rsp_if;
   logic                  valid;
   logic                  ready;
   bfec_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/bfec_ram.sv
`default_nettype none

module bfec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/bfec_exec.sv
`default_nettype none

module bfec_exec (
   input  wire bfec_pkg::req_item_type   item,
   input  wire logic [7:0]               cur_byte,
   input  wire logic [11:0]              partner,
   input  wire bfec_pkg::exec_flags_type flags,
   output bfec_pkg::exec_ctl_type        ctl,
   output bfec_pkg::rsp_item_type        rsp
);

   logic [11:0] pnr;
   logic        pending;

   // partner of an address beyond the program reads as zero
   assign pnr = flags.pos_ok ? partner : 12'd0;

   always_comb begin
      ctl     = '0;
      rsp     = '0;
      pending = 1'b0;
      if (item.req_type == bfec_pkg::REQ_LOAD) begin
         if (flags.pos_ok && item.symbol == bfec_pkg::SYM_OPEN) begin
            if (flags.count_full) begin
               rsp.status = bfec_pkg::STATUS_NEST_OVERFLOW;
            end else begin
               ctl.push = 1'b1;
            end
         end else if (flags.pos_ok && item.symbol == bfec_pkg::SYM_CLOSE) begin
            if (flags.count_zero) begin
               rsp.status = bfec_pkg::STATUS_UNMATCHED_CLOSE;
            end else begin
               ctl.pop = 1'b1;
            end
         end
         if (item.load_last) begin
            // opens still pending after this item
            pending = ctl.push || (ctl.pop ? !flags.count_one : !flags.count_zero);
            if (pending && rsp.status == bfec_pkg::STATUS_OK) begin
               rsp.status = bfec_pkg::STATUS_UNMATCHED_OPEN;
            end
            ctl.clear_count = 1'b1;
         end
      end else begin
         rsp.next_pc = {1'b0, item.position} + 13'd1;
         case (item.symbol)
            bfec_pkg::SYM_RIGHT: begin
               if (flags.ptr_at_last) begin
                  rsp.status = bfec_pkg::STATUS_OVERFLOW;
               end else begin
                  ctl.ptr_inc = 1'b1;
               end
            end
            bfec_pkg::SYM_LEFT: begin
               if (flags.ptr_at_zero) begin
                  rsp.status = bfec_pkg::STATUS_UNDERFLOW;
               end else begin
                  ctl.ptr_dec = 1'b1;
               end
            end
            bfec_pkg::SYM_PLUS: begin
               ctl.tape_we    = 1'b1;
               ctl.tape_wdata = cur_byte + 8'd1;
            end
            bfec_pkg::SYM_MINUS: begin
               ctl.tape_we    = 1'b1;
               ctl.tape_wdata = cur_byte - 8'd1;
            end
            bfec_pkg::SYM_DOT: begin
               rsp.out_valid = 1'b1;
               rsp.out_byte  = cur_byte;
            end
            bfec_pkg::SYM_COMMA: begin
               ctl.tape_we    = 1'b1;
               ctl.tape_wdata = item.in_byte;
            end
            bfec_pkg::SYM_OPEN: begin
               if (cur_byte == 8'd0) begin
                  rsp.next_pc = {1'b0, pnr} + 13'd1;
               end
            end
            bfec_pkg::SYM_CLOSE: begin
               rsp.next_pc = {1'b0, pnr};
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### design/brainfuck_execution_core_unit.sv
`default_nettype none
// channel   direction  beat
// req_ch    in         load or execute item (character, position, last, byte)
// rsp_ch    out        next_pc, out_valid, out_byte, status
//
// execute items and most load items: accept with memory reads, then update once the result register has room
// a load ']' that pairs with an open bracket adds a link state: the partner table's single write
// port writes the second link entry there
// after reset a clearing pass zeroes every tape cell, one cell a cycle;
// no item is accepted meanwhile
// the result register lets the next item be accepted while a result waits on rsp_ch

`include "brainfuck_execution_core_unit_defines.svh"

module brainfuck_execution_core_unit #(
   parameter int TAPE_CELLS  = 32768,
   parameter int PROGRAM_LEN = 4096,
   parameter int NEST_DEPTH  = 256
) (
   input wire logic   clock,
   input wire logic   reset,
   bfec_req_if.sink   req_ch,
   bfec_rsp_if.source rsp_ch
);

   // tape pointer width
   localparam int DW = $clog2(TAPE_CELLS);
   // partner table only covers addresses a 12-bit position can reach
   localparam int PDEPTH = (PROGRAM_LEN < 4096) ? PROGRAM_LEN : 4096;
   localparam int PAW = $clog2(PDEPTH);
   // open stack addressing and pending count
   localparam int SAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int CW = $clog2(NEST_DEPTH + 1);
   localparam logic [DW-1:0] TAPE_LAST = DW'(TAPE_CELLS - 1);
   localparam logic [CW-1:0] NEST_CNT = CW'(NEST_DEPTH);

   bfec_pkg::core_state_type state_ff, state_in;
   bfec_pkg::req_item_type   item_ff;
   bfec_pkg::rsp_item_type   rsp_item_ff;
   bfec_pkg::exec_flags_type flags;
   bfec_pkg::exec_ctl_type   ctl;
   bfec_pkg::rsp_item_type   ex_rsp;

   logic [DW-1:0]  data_ptr_ff;
   logic [DW-1:0]  clr_addr_ff;
   logic [CW-1:0]  open_count_ff;
   logic [PAW-1:0] link_addr_ff;
   logic [11:0]    link_data_ff;
   logic           rsp_valid_ff;

   logic           accept;
   logic           go;
   logic           op_ok;
   logic [CW-1:0]  count_dec;

   // memory ports
   logic           tape_we;
   logic [DW-1:0]  tape_waddr;
   logic [7:0]     tape_wdata;
   logic [7:0]     tape_rd;
   logic           pnr_we;
   logic [PAW-1:0] pnr_waddr;
   logic [11:0]    pnr_wdata;
   logic [11:0]    pnr_rd;
   logic           stk_we;
   logic [11:0]    stk_rd;

   assign accept    = req_ch.valid && req_ch.ready;
   assign count_dec = open_count_ff - CW'(1);
   // popped open bracket address lies inside the partner table
   assign op_ok     = {20'd0, stk_rd} < 32'(PROGRAM_LEN);

   // next state, handshake and update strobe
   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      go           = 1'b0;
      unique case (state_ff)
         bfec_pkg::ST_CLEAR: begin
            if (clr_addr_ff == TAPE_LAST) begin
               state_in = bfec_pkg::ST_IDLE;
            end
         end
         bfec_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = bfec_pkg::ST_EXEC;
            end
         end
         bfec_pkg::ST_EXEC: begin
            // wait for room in the result register
            go = !rsp_valid_ff || rsp_ch.ready;
            if (go) begin
               state_in = (ctl.pop && op_ok) ? bfec_pkg::ST_LINK : bfec_pkg::ST_IDLE;
            end
         end
         bfec_pkg::ST_LINK: begin
            state_in = bfec_pkg::ST_IDLE;
         end
         default: begin
            state_in = bfec_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfec_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // conditions handed to the decoder
   assign flags.pos_ok      = {20'd0, item_ff.position} < 32'(PROGRAM_LEN);
   assign flags.ptr_at_zero = data_ptr_ff == '0;
   assign flags.ptr_at_last = data_ptr_ff == TAPE_LAST;
   assign flags.count_zero  = open_count_ff == '0;
   assign flags.count_one   = open_count_ff == CW'(1);
   assign flags.count_full  = open_count_ff == NEST_CNT;

   bfec_exec u_exec (
      .item     (item_ff),
      .cur_byte (tape_rd),
      .partner  (pnr_rd),
      .flags    (flags),
      .ctl      (ctl),
      .rsp      (ex_rsp)
   );

   // tape: clearing pass writes zeros, otherwise read at accept and written back on update
   assign tape_we    = (state_ff == bfec_pkg::ST_CLEAR) || (go && ctl.tape_we);
   assign tape_waddr = (state_ff == bfec_pkg::ST_CLEAR) ? clr_addr_ff : data_ptr_ff;
   assign tape_wdata = (state_ff == bfec_pkg::ST_CLEAR) ? 8'd0 : ctl.tape_wdata;

   bfec_ram #(
      .WIDTH (8),
      .DEPTH (TAPE_CELLS)
   ) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_waddr),
      .wr_data (tape_wdata),
      .rd_en   (accept),
      .rd_addr (data_ptr_ff),
      .rd_data (tape_rd)
   );

   // partner table: close entry written on pop, open entry in the link cycle
   assign pnr_we    = (go && ctl.pop) || (state_ff == bfec_pkg::ST_LINK);
   assign pnr_waddr = (state_ff == bfec_pkg::ST_LINK) ? link_addr_ff
                                                      : item_ff.position[PAW-1:0];
   assign pnr_wdata = (state_ff == bfec_pkg::ST_LINK) ? link_data_ff : stk_rd;

   bfec_ram #(
      .WIDTH (12),
      .DEPTH (PDEPTH)
   ) u_partner (
      .clock   (clock),
      .wr_en   (pnr_we),
      .wr_addr (pnr_waddr),
      .wr_data (pnr_wdata),
      .rd_en   (accept),
      .rd_addr (req_ch.payload.position[PAW-1:0]),
      .rd_data (pnr_rd)
   );

   // open stack: top entry read at accept, push writes at the count
   assign stk_we = go && ctl.push;

   bfec_ram #(
      .WIDTH (12),
      .DEPTH (NEST_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (open_count_ff[SAW-1:0]),
      .wr_data (item_ff.position),
      .rd_en   (accept),
      .rd_addr (count_dec[SAW-1:0]),
      .rd_data (stk_rd)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ptr_ff   <= '0;
         clr_addr_ff   <= '0;
         open_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (state_ff == bfec_pkg::ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + DW'(1);
         end
         if (go) begin
            if (ctl.ptr_inc) begin
               data_ptr_ff <= data_ptr_ff + DW'(1);
            end else if (ctl.ptr_dec) begin
               data_ptr_ff <= data_ptr_ff - DW'(1);
            end
            if (ctl.clear_count) begin
               open_count_ff <= '0;
            end else if (ctl.push) begin
               open_count_ff <= open_count_ff + CW'(1);
            end else if (ctl.pop) begin
               open_count_ff <= count_dec;
            end
         end
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_ch.payload;
      end
      if (go) begin
         rsp_item_ff  <= ex_rsp;
         link_addr_ff <= stk_rd[PAW-1:0];
         link_data_ff <= item_ff.position;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_item_ff;

   `BFEC_ASSERT_NXT(a_accept_to_exec, accept, state_ff == bfec_pkg::ST_EXEC, "accept lost")
   `BFEC_ASSERT_IMP(a_ptr_range, 1'b1, data_ptr_ff <= TAPE_LAST, "data pointer past tape")
   `BFEC_ASSERT_IMP(a_count_range, 1'b1, open_count_ff <= NEST_CNT, "open count past depth")
   `BFEC_ASSERT_IMP(a_rsp_from_exec, $rose(rsp_valid_ff), $past(go), "result without update")
   `BFEC_ASSERT_IMP(a_link_after_exec, state_ff == bfec_pkg::ST_LINK, $past(ctl.pop), "link order")

endmodule

`default_nettype wire

### sim/bfec_result_checker.sv
module bfec_result_checker
   import bfec_pkg::*;
#(
   parameter int TAPE_CELLS  = 32768,
   parameter int PROGRAM_LEN = 4096,
   parameter int NEST_DEPTH  = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   bfec_req_if       req_mon,
   bfec_rsp_if       rsp_mon,
   output int        mismatches,
   output int        pending
);

   logic [BYTE_W-1:0] tape_cells [TAPE_CELLS];
   logic [POS_W-1:0]  link_table [PROGRAM_LEN];
   logic [POS_W-1:0]  open_marks [NEST_DEPTH];
   int                cell_ptr   = 0;
   int                open_depth = 0;
   int                fail_count = 0;
   int                waiting    = 0;
   rsp_item_type      owed_results [$];

   assign mismatches = fail_count;
   assign pending    = waiting;

   // result of one beat, updating the shadow tape, pointer and bracket links
   function automatic rsp_item_type interpret_beat(input req_item_type b);
      rsp_item_type     r;
      logic [POS_W-1:0] op;
      logic             in_prog;
      r = '0;
      in_prog = int'(b.position) < PROGRAM_LEN;
      if (b.req_type == REQ_LOAD) begin
         if (in_prog && b.symbol == SYM_OPEN) begin
            if (open_depth >= NEST_DEPTH) begin
               r.status = STATUS_NEST_OVERFLOW;
            end else begin
               open_marks[open_depth] = b.position;
               open_depth++;
            end
         end else if (in_prog && b.symbol == SYM_CLOSE) begin
            if (open_depth == 0) begin
               r.status = STATUS_UNMATCHED_CLOSE;
            end else begin
               open_depth--;
               op = open_marks[open_depth];
               link_table[op] = b.position;
               link_table[b.position] = op;
            end
         end
         if (b.load_last) begin
            if (open_depth != 0 && r.status == STATUS_OK) r.status = STATUS_UNMATCHED_OPEN;
            open_depth = 0;
         end
      end else begin
         r.next_pc = PC_W'(b.position) + PC_W'(1);
         case (b.symbol)
            SYM_RIGHT: begin
               if (cell_ptr >= TAPE_CELLS - 1) r.status = STATUS_OVERFLOW;
               else cell_ptr++;
            end
            SYM_LEFT: begin
               if (cell_ptr == 0) r.status = STATUS_UNDERFLOW;
               else cell_ptr--;
            end
            SYM_PLUS:  tape_cells[cell_ptr] = tape_cells[cell_ptr] + 8'd1;
            SYM_MINUS: tape_cells[cell_ptr] = tape_cells[cell_ptr] - 8'd1;
            SYM_DOT: begin
               r.out_valid = 1'b1;
               r.out_byte  = tape_cells[cell_ptr];
            end
            SYM_COMMA: tape_cells[cell_ptr] = b.in_byte;
            SYM_OPEN: begin
               // beyond the program the partner reads as zero
               if (tape_cells[cell_ptr] == 8'd0)
                  r.next_pc = in_prog ? PC_W'(link_table[b.position]) + PC_W'(1) : PC_W'(1);
            end
            SYM_CLOSE: r.next_pc = in_prog ? PC_W'(link_table[b.position]) : '0;
            default: ;
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_item_type seen, want;
      if (reset) begin
         for (int i = 0; i < TAPE_CELLS; i++) tape_cells[i] = '0;
         cell_ptr   = 0;
         open_depth = 0;
         owed_results.delete();
      end else begin
         // a result never leaves in the cycle its beat is accepted, so compare first
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = rsp_mon.payload;
            if (owed_results.size() == 0) begin
               $error("result beat with nothing outstanding: %h", seen);
               fail_count++;
            end else begin
               want = owed_results.pop_front();
               if (seen.next_pc !== want.next_pc) begin
                  $error("next_pc expected %0d got %0d", want.next_pc, seen.next_pc);
                  fail_count++;
               end
               if (seen.out_valid !== want.out_valid) begin
                  $error("out_valid expected %0d got %0d", want.out_valid, seen.out_valid);
                  fail_count++;
               end
               if (seen.out_byte !== want.out_byte) begin
                  $error("out_byte expected %0d got %0d", want.out_byte, seen.out_byte);
                  fail_count++;
               end
               if (seen.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, seen.status);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) owed_results.push_back(interpret_beat(req_mon.payload));
      end
      waiting = owed_results.size();
   end

endmodule

### sim/brainfuck_execution_core_unit_test.sv
module brainfuck_execution_core_unit_test;
   import bfec_pkg::*;

   localparam int TAPE_CELLS   = 32768;
   localparam int PROGRAM_LEN  = 4096;
   localparam int NEST_DEPTH   = 256;
   localparam int RESET_CYCLES = 11;
   // the limit also covers the quiet clearing pass after reset
   localparam int STALL_LIMIT  = 4 * TAPE_CELLS + 20000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_BEATS = 1000;
   localparam int WALK_STEPS   = 40;

   logic clock = 1'b0;
   logic reset;

   bfec_req_if req_ch ();
   bfec_rsp_if rsp_ch ();

   int mismatches;
   int pending;

   // sender and receiver bookkeeping
   int burst_left    = 0;
   int beats_sent    = 0;
   int hold_requests = 0;
   int holds_done    = 0;
   int idle_cycles   = 0;

   // program positions whose partner entry has been written by some load
   bit linked [PROGRAM_LEN];
   int linked_pos [$];
   // opens still waiting for their close in the program being loaded
   int open_trail [$];

   always #10 clock = ~clock;

   brainfuck_execution_core_unit #(
      .TAPE_CELLS  (TAPE_CELLS),
      .PROGRAM_LEN (PROGRAM_LEN),
      .NEST_DEPTH  (NEST_DEPTH)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bfec_result_checker #(
      .TAPE_CELLS  (TAPE_CELLS),
      .PROGRAM_LEN (PROGRAM_LEN),
      .NEST_DEPTH  (NEST_DEPTH)
   ) result_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // watchdog: ends the run after too long without any beat on either side
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stall patterns that change from span to span, plus the long hold-off
   initial begin
      int  mode;
      int  span;
      logic take;
      forever begin
         if (holds_done < hold_requests) begin
            // long hold-off so the core backs up and stalls its input
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 120);
            repeat (span) begin
               case (mode)
                  0: take = 1'b1;
                  1: take = 1'($urandom_range(0, 1));
                  2: take = ($urandom_range(0, 3) != 0);
                  default: take = ($urandom_range(0, 3) == 0);
               endcase
               rsp_ch.ready <= take;
               @(posedge clock);
            end
         end
      end
   end

   // offer one beat and wait for its acceptance; bursts with random gaps between
   task automatic offer_beat(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         // a third of the bursts follow on with no gap at all
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= it;
      do @(posedge clock); while (!req_ch.ready);
      beats_sent++;
   endtask

   // stop sending until every outstanding result has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic void note_link(input int p);
      if (!linked[p]) begin
         linked[p] = 1'b1;
         linked_pos.push_back(p);
      end
   endfunction

   // any byte but a bracket, leaning toward the plain commands
   function automatic logic [7:0] plain_symbol();
      logic [7:0] s;
      case ($urandom_range(0, 11))
         0: s = SYM_RIGHT;
         1: s = SYM_LEFT;
         2: s = SYM_PLUS;
         3: s = SYM_MINUS;
         4: s = SYM_DOT;
         5: s = SYM_COMMA;
         default: begin
            do s = 8'($urandom_range(0, 255)); while (s == SYM_OPEN || s == SYM_CLOSE);
         end
      endcase
      return s;
   endfunction

   // load beat; tracks pairing only to know which partner entries exist
   task automatic load_char(input logic [7:0] sym, input int pos, input bit last);
      req_item_type it;
      int           op;
      it.req_type  = REQ_LOAD;
      it.symbol    = sym;
      it.position  = pos[POS_W-1:0];
      it.load_last = last;
      it.in_byte   = 8'($urandom_range(0, 255));
      if (sym == SYM_OPEN) begin
         if (open_trail.size() < NEST_DEPTH) open_trail.push_back(pos);
      end else if (sym == SYM_CLOSE && open_trail.size() > 0) begin
         op = open_trail.pop_back();
         note_link(op);
         note_link(pos);
      end
      if (last) open_trail.delete();
      offer_beat(it);
   endtask

   // execute beat; load_last is a don't-care here so it is randomized
   task automatic exec_char(input logic [7:0] sym, input int pos, input logic [7:0] data_in);
      req_item_type it;
      it.req_type  = REQ_EXEC;
      it.symbol    = sym;
      it.position  = pos[POS_W-1:0];
      it.load_last = 1'($urandom_range(0, 1));
      it.in_byte   = data_in;
      offer_beat(it);
   endtask

   // random instruction; brackets only where a partner entry was written
   task automatic exec_random();
      int         r;
      int         pos;
      logic [7:0] sym;
      r   = $urandom_range(0, 99);
      pos = $urandom_range(0, PROGRAM_LEN - 1);
      if (r < 14) sym = SYM_RIGHT;
      else if (r < 28) sym = SYM_LEFT;
      else if (r < 42) sym = SYM_PLUS;
      else if (r < 52) sym = SYM_MINUS;
      else if (r < 64) sym = SYM_DOT;
      else if (r < 74) sym = SYM_COMMA;
      else if (r < 90 && linked_pos.size() > 0) begin
         sym = (r < 84) ? SYM_OPEN : SYM_CLOSE;
         pos = linked_pos[$urandom_range(0, linked_pos.size() - 1)];
      end else sym = plain_symbol();
      exec_char(sym, pos, 8'($urandom_range(0, 255)));
   endtask

   // short program at a random base: balanced brackets, or random garbage when broken
   task automatic load_program(input bit broken);
      int         len;
      int         base;
      int         depth;
      int         r;
      bit         last;
      logic [7:0] sym;
      len   = $urandom_range(2, 40);
      base  = $urandom_range(0, PROGRAM_LEN - len);
      depth = 0;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 9);
         if (broken) begin
            if (r < 3) sym = SYM_OPEN;
            else if (r < 6) sym = SYM_CLOSE;
            else sym = 8'($urandom_range(0, 255));
         end else if (depth > 0 && depth >= len - i) begin
            sym = SYM_CLOSE;   // only room left to close what is open
         end else if (r < 3 && depth + 1 < len - i) begin
            sym = SYM_OPEN;
         end else if (r < 5 && depth > 0) begin
            sym = SYM_CLOSE;
         end else begin
            sym = plain_symbol();
         end
         if (sym == SYM_OPEN) depth++;
         else if (sym == SYM_CLOSE && depth > 0) depth--;
         // broken programs sometimes end early in the middle
         last = (i == len - 1) || (broken && r == 9);
         load_char(sym, base + i, last);
      end
   endtask

   initial begin
      int  start;
      int  r;
      bit  held;
      bit  drained;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      reset          <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: link the two ends of the program space
      load_char(SYM_OPEN, 0, 1'b0);
      load_char(SYM_CLOSE, PROGRAM_LEN - 1, 1'b1);
      // close with nothing open, open left at the end, a last close with nothing open, a plain last character
      load_char(SYM_CLOSE, 10, 1'b0);
      load_char(SYM_OPEN, 20, 1'b1);
      load_char(SYM_CLOSE, 40, 1'b1);
      load_char(8'h41, 50, 1'b1);
      // inner pair closes, outer open still pending at the last character
      load_char(SYM_OPEN, 30, 1'b0);
      load_char(SYM_OPEN, 31, 1'b0);
      load_char(SYM_CLOSE, 32, 1'b1);

      // jumps at the ends: skip past the top, loop back to zero
      exec_char(SYM_OPEN, 0, 8'h00);
      exec_char(SYM_CLOSE, PROGRAM_LEN - 1, 8'h00);
      exec_char(SYM_LEFT, 7, 8'h00);   // pointer underflow
      exec_char(SYM_PLUS, 8, 8'h00);
      exec_char(SYM_OPEN, 0, 8'h00);   // nonzero cell falls through
      exec_char(SYM_MINUS, 9, 8'h00);
      exec_char(SYM_MINUS, 9, 8'h00);  // wraps to 255
      exec_char(SYM_DOT, PROGRAM_LEN - 1, 8'h00);
      exec_char(SYM_COMMA, 11, 8'hFF);
      exec_char(SYM_COMMA, 12, 8'h00);
      exec_char(SYM_DOT, 13, 8'hFF);
      exec_char(SYM_RIGHT, 14, 8'h00);
      exec_char(SYM_COMMA, 15, 8'h5A);
      exec_char(SYM_LEFT, 16, 8'hA5);
      exec_char(8'hFF, PROGRAM_LEN - 1, 8'hFF);
      exec_char(8'h00, 0, 8'h00);

      // walk the pointer a short way out, work on the cell there, and back below zero
      for (int i = 0; i < WALK_STEPS; i++)
         exec_char(SYM_RIGHT, $urandom_range(0, PROGRAM_LEN - 1), 8'($urandom_range(0, 255)));
      exec_char(SYM_PLUS, 101, 8'h00);
      exec_char(SYM_DOT, 102, 8'h00);
      exec_char(SYM_COMMA, 103, 8'hC3);
      exec_char(SYM_DOT, 104, 8'h00);
      for (int i = 0; i < WALK_STEPS; i++)
         exec_char(SYM_LEFT, $urandom_range(0, PROGRAM_LEN - 1), 8'($urandom_range(0, 255)));
      exec_char(SYM_LEFT, 105, 8'h00);   // pointer underflow

      // nesting to the full depth, one open too many, then close them all
      for (int i = 0; i < NEST_DEPTH; i++) load_char(SYM_OPEN, 100 + i, 1'b0);
      load_char(SYM_OPEN, 100 + NEST_DEPTH, 1'b0);
      for (int i = 0; i < NEST_DEPTH; i++)
         load_char(SYM_CLOSE, 101 + NEST_DEPTH + i, i == NEST_DEPTH - 1);
      exec_char(SYM_OPEN, 100, 8'h00);
      exec_char(SYM_CLOSE, 100 + 2 * NEST_DEPTH, 8'h00);

      // random: mostly well-formed programs followed by runs of instructions on them
      start   = beats_sent;
      held    = 1'b0;
      drained = 1'b0;
      while (beats_sent < start + RANDOM_BEATS) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            load_program(1'b0);
            repeat ($urandom_range(5, 30)) exec_random();
         end else if (r < 75) begin
            load_program(1'b1);
         end else begin
            repeat ($urandom_range(5, 30)) exec_random();
         end
         // receiver hold-off while we keep offering beats
         if (!held && beats_sent > start + 300) begin
            hold_requests++;
            held = 1'b1;
         end
         if (!drained && beats_sent > start + 650) begin
            drain_results();
            drained = 1'b1;
         end
      end

      // let everything come back, then wait for stray results before the verdict
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/bfec_pkg.sv
design/bfec_chan_if.sv
design/bfec_ram.sv
design/bfec_exec.sv
design/brainfuck_execution_core_unit.sv
sim/bfec_result_checker.sv
sim/brainfuck_execution_core_unit_test.sv
